>>> hw/rtl/sorted_priority_queue_defines.svh
// Assertion helpers for the sorted priority queue.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: check failed");
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: check failed");
`else
`define SPQ_ASSERT_NOW(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // defaults for the top level parameters
    localparam int DEPTH_DEF          = 16;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int PRIORITY_WIDTH_DEF = 8;

    // fixed port widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int POS_W    = 4;
    localparam int TOTAL_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]   head_data;
        logic [PRIO_W-1:0]   head_priority;
        logic [TOTAL_W-1:0]  entry_total;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

>>> hw/rtl/spq_mem.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module spq_mem #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps

// Operation sequencer: walks the slot memories to shift entries on
// insert and remove, keeps the count and a copy of the head entry.
module spq_ctrl #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int SW    = spq_pkg::DATA_WIDTH_DEF,
    parameter int PRW   = spq_pkg::PRIORITY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spq_pkg::OP_W-1:0]      i_op,
    input  logic [spq_pkg::DATA_W-1:0]    i_item_data,
    input  logic [spq_pkg::PRIO_W-1:0]    i_item_priority,
    input  logic [spq_pkg::POS_W-1:0]     i_position,
    output logic                          o_idle,
    output logic                          o_done,
    input  logic                          i_take,
    output spq_pkg::t_result              o_result,
    output logic                          o_we_data,
    output logic                          o_we_prio,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output logic [SW-1:0]                 o_wdata_data,
    output logic [PRW-1:0]                o_wdata_prio,
    output logic                          o_re,
    output logic [$clog2(DEPTH)-1:0]      o_raddr,
    input  logic [SW-1:0]                 i_rdata_data,
    input  logic [PRW-1:0]                i_rdata_prio
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PXW = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_HEAD = 3'd2;
    localparam logic [2:0] S_REM      = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0]                   r_state,    n_state;
    logic [CW-1:0]                r_occ,      n_occ;
    logic [CW-1:0]                r_idx,      n_idx;
    logic [SW-1:0]                r_new_data, n_new_data;
    logic [PRW-1:0]               r_new_prio, n_new_prio;
    logic [SW-1:0]                r_head_data, n_head_data;
    logic [PRW-1:0]               r_head_prio, n_head_prio;
    logic [spq_pkg::STATUS_W-1:0] r_status,   n_status;

    logic [PXW-1:0] w_pos_ext;
    logic [PXW-1:0] w_occ_ext;

    assign w_pos_ext = PXW'(i_position);
    assign w_occ_ext = PXW'(r_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_new_data  <= n_new_data;
        r_new_prio  <= n_new_prio;
        r_head_data <= n_head_data;
        r_head_prio <= n_head_prio;
        r_status    <= n_status;
    end

    // Reads and writes never hit the same slot in one cycle: insert writes
    // slot k while reading k-2, remove writes idx-1 while reading idx+1.
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_new_data   = r_new_data;
        n_new_prio   = r_new_prio;
        n_head_data  = r_head_data;
        n_head_prio  = r_head_prio;
        n_status     = r_status;
        o_we_data    = 1'b0;
        o_we_prio    = 1'b0;
        o_waddr      = '0;
        o_wdata_data = r_new_data;
        o_wdata_prio = r_new_prio;
        o_re         = 1'b0;
        o_raddr      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_new_data = SW'(i_item_data);
                    n_new_prio = PRW'(i_item_priority);
                    n_status   = spq_pkg::ST_OK;
                    n_state    = S_FIN;
                    case (i_op)
                        spq_pkg::OP_INSERT: begin
                            if (r_occ == CW'(DEPTH)) begin
                                n_status = spq_pkg::ST_FULL;
                            end else if (r_occ == '0) begin
                                o_we_data    = 1'b1;
                                o_we_prio    = 1'b1;
                                o_wdata_data = SW'(i_item_data);
                                o_wdata_prio = PRW'(i_item_priority);
                                n_head_data  = SW'(i_item_data);
                                n_head_prio  = PRW'(i_item_priority);
                                n_occ        = CW'(1);
                            end else begin
                                // scan from the tail toward the head
                                o_re    = 1'b1;
                                o_raddr = AW'(r_occ - CW'(1));
                                n_idx   = r_occ;
                                n_state = S_INS;
                            end
                        end
                        spq_pkg::OP_READ: begin
                            if (r_occ == '0) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end
                        end
                        spq_pkg::OP_UPDATE: begin
                            if (w_pos_ext >= w_occ_ext) begin
                                n_status = spq_pkg::ST_RANGE;
                            end else begin
                                o_we_data    = 1'b1;
                                o_waddr      = AW'(w_pos_ext);
                                o_wdata_data = SW'(i_item_data);
                                if (w_pos_ext == '0) begin
                                    n_head_data = SW'(i_item_data);
                                end
                            end
                        end
                        spq_pkg::OP_REMOVE: begin
                            if (r_occ == '0) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end else if (r_occ == CW'(1)) begin
                                n_occ = '0;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = AW'(1);
                                n_idx   = CW'(1);
                                n_state = S_REM;
                            end
                        end
                        default: begin
                            n_status = spq_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_INS: begin
                // slot idx-1 is on the read bus; strictly larger moves up one
                o_waddr = AW'(r_idx);
                if (i_rdata_prio > r_new_prio) begin
                    o_we_data    = 1'b1;
                    o_we_prio    = 1'b1;
                    o_wdata_data = i_rdata_data;
                    o_wdata_prio = i_rdata_prio;
                    if (r_idx == CW'(1)) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = AW'(r_idx - CW'(2));
                        n_idx   = r_idx - CW'(1);
                    end
                end else begin
                    o_we_data = 1'b1;
                    o_we_prio = 1'b1;
                    n_occ     = r_occ + CW'(1);
                    n_state   = S_FIN;
                end
            end

            S_INS_HEAD: begin
                o_we_data   = 1'b1;
                o_we_prio   = 1'b1;
                n_head_data = r_new_data;
                n_head_prio = r_new_prio;
                n_occ       = r_occ + CW'(1);
                n_state     = S_FIN;
            end

            S_REM: begin
                // slot idx is on the read bus; move it down one
                o_we_data    = 1'b1;
                o_we_prio    = 1'b1;
                o_waddr      = AW'(r_idx - CW'(1));
                o_wdata_data = i_rdata_data;
                o_wdata_prio = i_rdata_prio;
                if (r_idx == CW'(1)) begin
                    n_head_data = i_rdata_data;
                    n_head_prio = i_rdata_prio;
                end
                if ((r_idx + CW'(1)) < r_occ) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_idx + CW'(1));
                    n_idx   = r_idx + CW'(1);
                end else begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_FIN);

    always_comb begin
        o_result.head_data     = (r_occ == '0) ? '0 : spq_pkg::DATA_W'(r_head_data);
        o_result.head_priority = (r_occ == '0) ? '0 : spq_pkg::PRIO_W'(r_head_prio);
        o_result.entry_total   = spq_pkg::TOTAL_W'(r_occ);
        o_result.status        = r_status;
    end

endmodule

>>> hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue, stable: entries are kept in ascending priority
// number, equal priorities in arrival order.
// Input channel (i_valid / o_ready) carries one operation item: insert,
// read head, overwrite data at a position, or remove head. Output channel
// (o_valid / i_ready) returns one item per operation: head entry after the
// operation (zero when empty), entry count and status.
// Entries sit in two RAMs with registered reads (data, priority). Insert and
// remove move entries one slot per cycle through the single RAM port pair:
// insert scans from the tail and moves each strictly larger entry up,
// remove moves every entry behind the head down. Read, update, any
// flagged op, insert into an empty queue and remove of a sole entry
// go straight to the result. One operation is in flight at a time, so
// the next item is taken only after the previous one has finished;
// o_ready returns after the result has moved into the output register.
// A stalled receiver holds the output register; the finished operation
// then waits in the sequencer and no new item is taken.
// Reset (synchronous, active low) empties the queue at once; slot RAMs are
// not cleared, only slots below the count are ever read.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH     = spq_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [spq_pkg::OP_W-1:0]         i_op,
    input  logic [spq_pkg::DATA_W-1:0]       i_item_data,
    input  logic [spq_pkg::PRIO_W-1:0]       i_item_priority,
    input  logic [spq_pkg::POS_W-1:0]        i_position,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [spq_pkg::DATA_W-1:0]       o_head_data,
    output logic [spq_pkg::PRIO_W-1:0]       o_head_priority,
    output logic [spq_pkg::TOTAL_W-1:0]      o_entry_total,
    output logic [spq_pkg::STATUS_W-1:0]     o_status
);

    // stored widths: data and priority ports cap what can be kept
    localparam int SW  = (DATA_WIDTH < spq_pkg::DATA_W) ? DATA_WIDTH : spq_pkg::DATA_W;
    localparam int PRW = (PRIORITY_WIDTH < spq_pkg::PRIO_W) ? PRIORITY_WIDTH
                                                             : spq_pkg::PRIO_W;
    localparam int AW  = $clog2(DEPTH);

    logic             w_idle;
    logic             w_done;
    logic             w_take;
    logic             w_start;
    spq_pkg::t_result w_result;

    logic           w_we_data;
    logic           w_we_prio;
    logic [AW-1:0]  w_waddr;
    logic [SW-1:0]  w_wdata_data;
    logic [PRW-1:0] w_wdata_prio;
    logic           w_re;
    logic [AW-1:0]  w_raddr;
    logic [SW-1:0]  w_rdata_data;
    logic [PRW-1:0] w_rdata_prio;

    logic             r_out_valid;
    spq_pkg::t_result r_out;

    assign o_ready = w_idle;
    assign w_start = i_valid && w_idle;
    // finished result moves out when the output register is free or drains
    assign w_take  = w_done && (!r_out_valid || i_ready);

    spq_ctrl #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .PRW   (PRW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_op            (i_op),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .i_position      (i_position),
        .o_idle          (w_idle),
        .o_done          (w_done),
        .i_take          (w_take),
        .o_result        (w_result),
        .o_we_data       (w_we_data),
        .o_we_prio       (w_we_prio),
        .o_waddr         (w_waddr),
        .o_wdata_data    (w_wdata_data),
        .o_wdata_prio    (w_wdata_prio),
        .o_re            (w_re),
        .o_raddr         (w_raddr),
        .i_rdata_data    (w_rdata_data),
        .i_rdata_prio    (w_rdata_prio)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem_data (
        .i_clk   (i_clk),
        .i_we    (w_we_data),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_data)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (PRW)
    ) u_mem_prio (
        .i_clk   (i_clk),
        .i_we    (w_we_prio),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_prio),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_prio)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_head_data     = r_out.head_data;
    assign o_head_priority = r_out.head_priority;
    assign o_entry_total   = r_out.entry_total;
    assign o_status        = r_out.status;

    // one operation at a time: an accepted item makes the block busy
    `SPQ_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // a finished operation is held until the output register takes it
    `SPQ_ASSERT_NEXT(a_done_held, w_done && !w_take, w_done)
    // empty status only with nothing stored
    `SPQ_ASSERT_NOW(a_empty_count, o_valid && o_status == spq_pkg::ST_EMPTY, o_entry_total == '0)
    // full status only at capacity
    `SPQ_ASSERT_NOW(a_full_count, o_valid && o_status == spq_pkg::ST_FULL,
                    o_entry_total == spq_pkg::TOTAL_W'(DEPTH))

endmodule

>>> tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1400;
    // Limit covers the slowest item, plus sender gap, receiver stall
    // and one long hold-off; this is many times the worst correct run.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 700;    // items accepted before the hold-off
    localparam int DRAIN_CYCLES = 40;     // quiet tail after the last result
    localparam int MAX_PRINTS   = 40;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // One row of directed stimulus. When 'checked' is set, 'want' is the
    // result typed in by hand; otherwise the shadow queue supplies it.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        logic [POS_W-1:0]  pos;
        logic              checked;
        t_result           want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;
    localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
        // empty queue: read, remove and update are all flagged
        '{OP_READ,   32'h0000_0000, 8'h00, 4'd0,  1'b1, '{32'h0, 8'h00, 5'd0, ST_EMPTY}},
        '{OP_REMOVE, 32'h0000_0000, 8'h00, 4'd0,  1'b1, '{32'h0, 8'h00, 5'd0, ST_EMPTY}},
        '{OP_UPDATE, 32'hFFFF_FFFF, 8'h00, 4'd0,  1'b1, '{32'h0, 8'h00, 5'd0, ST_RANGE}},
        '{OP_UPDATE, 32'hFFFF_FFFF, 8'h00, 4'd15, 1'b1, '{32'h0, 8'h00, 5'd0, ST_RANGE}},
        // extremes: all-ones item, then an all-zero item that jumps ahead of it
        '{OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 4'd0,  1'b1,
          '{32'hFFFF_FFFF, 8'hFF, 5'd1, ST_OK}},
        '{OP_INSERT, 32'h0000_0000, 8'h00, 4'd15, 1'b1, '{32'h0, 8'h00, 5'd2, ST_OK}},
        // update exactly at the count is out of range
        '{OP_UPDATE, 32'hDEAD_BEEF, 8'h00, 4'd2,  1'b1, '{32'h0, 8'h00, 5'd2, ST_RANGE}},
        '{OP_UPDATE, 32'hA5A5_A5A5, 8'h00, 4'd1,  1'b0, '0},
        // equal priority goes behind the current head
        '{OP_INSERT, 32'h5A5A_5A5A, 8'h00, 4'd0,  1'b0, '0},
        // fill up to the depth with mixed and repeated priorities
        '{OP_INSERT, 32'h0000_0001, 8'd200, 4'd3,  1'b0, '0},
        '{OP_INSERT, 32'h8000_0000, 8'd7,   4'd4,  1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 8'hFF,  4'd5,  1'b0, '0},
        '{OP_INSERT, 32'hFFFF_0000, 8'd0,   4'd6,  1'b0, '0},
        '{OP_INSERT, 32'h0000_FFFF, 8'd128, 4'd7,  1'b0, '0},
        '{OP_INSERT, 32'h0F0F_0F0F, 8'd7,   4'd8,  1'b0, '0},
        '{OP_INSERT, 32'hF0F0_F0F0, 8'd1,   4'd9,  1'b0, '0},
        '{OP_INSERT, 32'h3333_3333, 8'hFE,  4'd10, 1'b0, '0},
        '{OP_INSERT, 32'hCCCC_CCCC, 8'd64,  4'd11, 1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 8'd7,   4'd12, 1'b0, '0},
        '{OP_INSERT, 32'hAAAA_AAAA, 8'd3,   4'd13, 1'b0, '0},
        '{OP_INSERT, 32'h0123_4567, 8'd100, 4'd14, 1'b0, '0},
        '{OP_INSERT, 32'h89AB_CDEF, 8'd0,   4'd1,  1'b0, '0},
        // insert into a full queue is refused; the zero head stays in front
        '{OP_INSERT, 32'h1357_9BDF, 8'd80,  4'd0,  1'b1, '{32'h0, 8'h00, 5'd16, ST_FULL}},
        // update the last and the first slot, then pop the head
        '{OP_UPDATE, 32'hFFFF_FFFF, 8'h00, 4'd15, 1'b0, '0},
        '{OP_UPDATE, 32'h2468_ACE0, 8'h00, 4'd0,  1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 8'h00, 4'd0,  1'b0, '0}
    };

    // DUT ports; every input starts at a known value
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                i_ready         = 1'b0;
    logic [OP_W-1:0]     i_op            = OP_READ;
    logic [DATA_W-1:0]   i_item_data     = '0;
    logic [PRIO_W-1:0]   i_item_priority = '0;
    logic [POS_W-1:0]    i_position      = '0;
    logic                o_ready;
    logic                o_valid;
    logic [DATA_W-1:0]   o_head_data;
    logic [PRIO_W-1:0]   o_head_priority;
    logic [TOTAL_W-1:0]  o_entry_total;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of the queue contents, head at index 0
    logic [DATA_W-1:0]   shadow_data[QUEUE_DEPTH];
    logic [PRIO_W-1:0]   shadow_prio[QUEUE_DEPTH];
    int                  shadow_count = 0;

    t_result             pending_results[$];
    int                  items_accepted = 0;
    int                  results_seen   = 0;
    int                  error_count    = 0;
    int                  cycle_count    = 0;
    int                  burst_left     = 0;

    sorted_priority_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_head_data     (o_head_data),
        .o_head_priority (o_head_priority),
        .o_entry_total   (o_entry_total),
        .o_status        (o_status)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one operation to the shadow queue and return the result item
    // the block should produce for it.
    function automatic t_result apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                                         logic [PRIO_W-1:0] prio, logic [POS_W-1:0] pos);
        t_result r;
        int      slot;
        int      k;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // stable: land behind every entry of equal or lower number
                    slot = 0;
                    while (slot < shadow_count && shadow_prio[slot] <= prio)
                        slot++;
                    for (k = shadow_count; k > slot; k--) begin
                        shadow_data[k] = shadow_data[k-1];
                        shadow_prio[k] = shadow_prio[k-1];
                    end
                    shadow_data[slot] = data;
                    shadow_prio[slot] = prio;
                    shadow_count++;
                end
            end
            OP_READ: begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
            end
            OP_UPDATE: begin
                if (int'(pos) >= shadow_count)
                    r.status = ST_RANGE;
                else
                    shadow_data[pos] = data;
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (k = 0; k + 1 < shadow_count; k++) begin
                        shadow_data[k] = shadow_data[k+1];
                        shadow_prio[k] = shadow_prio[k+1];
                    end
                    shadow_count--;
                end
            end
        endcase
        if (shadow_count == 0) begin
            r.head_data     = '0;
            r.head_priority = '0;
        end else begin
            r.head_data     = shadow_data[0];
            r.head_priority = shadow_prio[0];
        end
        r.entry_total = TOTAL_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < MAX_PRINTS)
            $display("mismatch at result %0d (t=%0t): %s got %0h want %0h",
                     results_seen, $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one item and hold it until the block takes it. The shadow queue
    // is advanced in this same process at the accepting edge, so the next
    // random item is drawn from up-to-date occupancy.
    task automatic offer_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                              logic [PRIO_W-1:0] prio, logic [POS_W-1:0] pos,
                              logic checked, t_result want);
        t_result predicted;
        i_valid         <= 1'b1;
        i_op            <= op;
        i_item_data     <= data;
        i_item_priority <= prio;
        i_position      <= pos;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = apply_op(op, data, prio, pos);
        pending_results.push_back(checked ? want : predicted);
        items_accepted++;
    endtask

    // Bursts of back-to-back items separated by idle gaps. valid is only
    // dropped here, never in the same step as the next offer raises it.
    task automatic sender_pause();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Result check: each accepted item is matched against the oldest
    // outstanding prediction, field by field.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item, status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_head_data !== want.head_data)
                    report_mismatch("head_data", o_head_data, want.head_data);
                if (o_head_priority !== want.head_priority)
                    report_mismatch("head_priority", o_head_priority, want.head_priority);
                if (o_entry_total !== want.entry_total)
                    report_mismatch("entry_total", o_entry_total, want.entry_total);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
            results_seen++;
        end
    end

    // Receiver: stretches of steady ready mixed with random stalls, and one
    // long hold-off mid-run so the block backs up and drops o_ready.
    initial begin : ready_pattern
        int  len;
        int  pct;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && items_accepted >= HOLD_AFTER) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            len = $urandom_range(4, 60);
            pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
            repeat (len) begin
                i_ready <= ($urandom_range(0, 99) < pct);
                @(posedge i_clk);
            end
        end
    end

    // Stimulus: directed table, then random episodes that push the queue
    // toward full, toward empty, or keep it churning.
    initial begin : stimulus
        int               mode;
        int               episode;
        int               roll;
        int               lim;
        int               n;
        int               random_sent;
        bit               narrow;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;

        random_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            offer_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].prio,
                       DIRECTED[i].pos, DIRECTED[i].checked, DIRECTED[i].want);
            sender_pause();
        end

        while (random_sent < RANDOM_ITEMS) begin
            mode    = $urandom_range(MODE_FILL, MODE_MIXED);
            episode = $urandom_range(8, 40);
            // narrow priorities give lots of ties to check arrival order
            narrow  = ($urandom_range(0, 2) == 0);
            for (n = 0; n < episode && random_sent < RANDOM_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL: begin
                        if (roll < 75)      op = OP_INSERT;
                        else if (roll < 85) op = OP_REMOVE;
                        else if (roll < 92) op = OP_READ;
                        else                op = OP_UPDATE;
                    end
                    MODE_DRAIN: begin
                        if (roll < 20)      op = OP_INSERT;
                        else if (roll < 75) op = OP_REMOVE;
                        else if (roll < 85) op = OP_READ;
                        else                op = OP_UPDATE;
                    end
                    default: begin
                        if (roll < 35)      op = OP_INSERT;
                        else if (roll < 65) op = OP_REMOVE;
                        else if (roll < 80) op = OP_READ;
                        else                op = OP_UPDATE;
                    end
                endcase
                // mostly aim positions at the live range and its upper edge
                if ($urandom_range(0, 9) < 7) begin
                    lim = (shadow_count < 15) ? shadow_count : 15;
                    pos = POS_W'($urandom_range(0, lim));
                end else begin
                    pos = POS_W'($urandom_range(0, 15));
                end
                offer_item(op, DATA_W'($urandom),
                           narrow ? PRIO_W'($urandom_range(0, 3))
                                  : PRIO_W'($urandom_range(0, 255)),
                           pos, 1'b0, '0);
                random_sent++;
                sender_pause();
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        // quiet tail: any extra item from the block is caught by the checker
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
